// ===== design/bmp565_pkg.sv =====
// Shared types, constants and helper functions for the BMP to RGB565 blend unit.
`timescale 1ns / 1ps

package bmp565_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Config fields are 11 bits wide, so no effective dimension exceeds this.
    localparam int DIM_W   = 11;
    localparam int DIM_MAX = 2 ** DIM_W - 1;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_BYTES_PER_PIXEL  = 3'd0;
    localparam logic [2:0] REG_BITFIELDS_FORMAT = 3'd1;
    localparam logic [2:0] REG_IMAGE_WIDTH      = 3'd2;
    localparam logic [2:0] REG_IMAGE_HEIGHT     = 3'd3;
    localparam logic [2:0] REG_ORIGIN_X         = 3'd4;
    localparam logic [2:0] REG_ORIGIN_Y         = 3'd5;
    localparam logic [2:0] REG_BLEND_COLOR      = 3'd6;
    localparam logic [2:0] REG_BLEND_MODE       = 3'd7;

    localparam logic [1:0] MODE_BACKGROUND     = 2'd0;
    localparam logic [1:0] MODE_COLOR          = 2'd1;
    localparam logic [1:0] MODE_TINTED         = 2'd2;
    localparam logic [1:0] MODE_BACKGROUND_ALT = 2'd3;

    localparam logic [2:0] BPP_16 = 3'd2;
    localparam logic [2:0] BPP_24 = 3'd3;
    localparam logic [2:0] BPP_32 = 3'd4;

    // G:R:B spread so that each channel has headroom for the blend product.
    localparam logic [31:0] GRB_MASK = 32'h07E0F81F;

    typedef struct packed {
        logic [2:0]  bytes_per_pixel;
        logic        bitfields_format;
        logic [10:0] image_width;
        logic [10:0] image_height;
        logic [15:0] origin_x;
        logic [15:0] origin_y;
        logic [15:0] blend_color;
        logic [7:0]  blend_mode;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [15:0] background_color;
    } in_item_t;

    typedef struct packed {
        logic [15:0] pixel_x;
        logic [15:0] pixel_y;
        logic [15:0] pixel_color;
        logic        last_pixel;
    } out_item_t;

    // One assembled pixel on its way from the front to the back.
    typedef struct packed {
        logic [7:0]  part0;
        logic [7:0]  part1;
        logic [7:0]  part2;
        logic [7:0]  final_byte;
        logic [15:0] background;
        logic [15:0] x;
        logic [15:0] y;
        logic        last;
    } job_t;

    function automatic logic [2:0] eff_bpp(input logic [2:0] v);
        eff_bpp = (v == BPP_24 || v == BPP_32) ? v : BPP_16;
    endfunction

    function automatic logic [15:0] blend565(input logic [15:0] s, input logic [15:0] d,
                                             input logic [4:0] a);
        logic [31:0] s2;
        logic [31:0] d2;
        logic [31:0] prod;
        logic [31:0] r;
        s2   = {s, s} & GRB_MASK;
        d2   = {d, d} & GRB_MASK;
        prod = (d2 - s2) * {27'd0, a};
        r    = ((prod >> 5) + s2) & GRB_MASK;
        blend565 = r[31:16] | r[15:0];
    endfunction

endpackage

// ===== design/bmp565_regs.sv =====
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps

module bmp565_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bmp565_pkg::ADDR_W-1:0] paddr,
    input  logic [bmp565_pkg::DATA_W-1:0] pwdata,
    output logic [bmp565_pkg::DATA_W-1:0] prdata,
    output logic                          pready,
    output bmp565_pkg::cfg_t              cfg,
    output logic                          restart
);
    import bmp565_pkg::*;

    localparam cfg_t CFG_RESET = '{
        bytes_per_pixel:  BPP_16,
        bitfields_format: 1'b0,
        image_width:      11'd1,
        image_height:     11'd1,
        origin_x:         16'd0,
        origin_y:         16'd0,
        blend_color:      16'd0,
        blend_mode:       8'd0
    };

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       restart_reg;
    logic       wr;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[ADDR_W-1:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            unique case (idx)
                REG_BYTES_PER_PIXEL:  cfg_next.bytes_per_pixel  = pwdata[2:0];
                REG_BITFIELDS_FORMAT: cfg_next.bitfields_format = pwdata[0];
                REG_IMAGE_WIDTH:      cfg_next.image_width      = pwdata[10:0];
                REG_IMAGE_HEIGHT:     cfg_next.image_height     = pwdata[10:0];
                REG_ORIGIN_X:         cfg_next.origin_x         = pwdata[15:0];
                REG_ORIGIN_Y:         cfg_next.origin_y         = pwdata[15:0];
                REG_BLEND_COLOR:      cfg_next.blend_color      = pwdata[15:0];
                REG_BLEND_MODE:       cfg_next.blend_mode       = pwdata[7:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_BYTES_PER_PIXEL:  prdata = {29'd0, cfg_reg.bytes_per_pixel};
            REG_BITFIELDS_FORMAT: prdata = {31'd0, cfg_reg.bitfields_format};
            REG_IMAGE_WIDTH:      prdata = {21'd0, cfg_reg.image_width};
            REG_IMAGE_HEIGHT:     prdata = {21'd0, cfg_reg.image_height};
            REG_ORIGIN_X:         prdata = {16'd0, cfg_reg.origin_x};
            REG_ORIGIN_Y:         prdata = {16'd0, cfg_reg.origin_y};
            REG_BLEND_COLOR:      prdata = {16'd0, cfg_reg.blend_color};
            REG_BLEND_MODE:       prdata = {24'd0, cfg_reg.blend_mode};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg     <= CFG_RESET;
            restart_reg <= 1'b0;
        end
        else
        begin
            cfg_reg     <= cfg_next;
            restart_reg <= wr;
        end
    end

    assign cfg     = cfg_reg;
    assign restart = restart_reg;

endmodule

// ===== design/bmp565_front.sv =====
// Front end: takes pixel-array bytes, tracks row and column, assembles pixels.
`timescale 1ns / 1ps

module bmp565_front #(
    parameter int MAX_WIDTH  = bmp565_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bmp565_pkg::MAX_HEIGHT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bmp565_pkg::cfg_t     cfg,
    input  logic                 restart,
    input  logic                 push,
    input  bmp565_pkg::in_item_t item,
    output logic                 full,
    input  logic                 q_full,
    output logic                 q_push,
    output bmp565_pkg::job_t     job
);
    import bmp565_pkg::*;

    localparam int EW    = (MAX_WIDTH > DIM_MAX) ? DIM_MAX : MAX_WIDTH;
    localparam int EH    = (MAX_HEIGHT > DIM_MAX) ? DIM_MAX : MAX_HEIGHT;
    localparam int COL_W = $clog2(EW + 1);
    localparam int ROW_W = $clog2(EH + 1);
    localparam int RB_W  = COL_W + 2;
    localparam logic [DIM_W-1:0] W_CLAMP = DIM_W'(EW);
    localparam logic [DIM_W-1:0] H_CLAMP = DIM_W'(EH);

    logic [1:0]       bip_reg;
    logic [RB_W-1:0]  row_byte_reg;
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [7:0]       part_reg [0:2];

    logic [2:0]       bpp;
    logic [COL_W-1:0] w_eff;
    logic [ROW_W-1:0] h_eff;
    logic [RB_W-1:0]  data_len;
    logic [RB_W:0]    row_len_ext;
    logic [RB_W-1:0]  row_len;
    logic [RB_W-1:0]  row_byte_inc;
    logic             row_end;
    logic             in_data;
    logic             pix_done;
    logic             accept;

    assign bpp = eff_bpp(cfg.bytes_per_pixel);

    always_comb
    begin
        priority if (cfg.image_width == '0)
            w_eff = COL_W'(1);
        else if (cfg.image_width > W_CLAMP)
            w_eff = COL_W'(EW);
        else
            w_eff = COL_W'(cfg.image_width);

        priority if (cfg.image_height == '0)
            h_eff = ROW_W'(1);
        else if (cfg.image_height > H_CLAMP)
            h_eff = ROW_W'(EH);
        else
            h_eff = ROW_W'(cfg.image_height);
    end

    always_comb
    begin
        unique case (bpp)
            BPP_24:  data_len = {1'b0, w_eff, 1'b0} + {2'b00, w_eff};
            BPP_32:  data_len = {w_eff, 2'b00};
            default: data_len = {1'b0, w_eff, 1'b0};
        endcase
    end

    // Rows are padded up to a multiple of four bytes.
    assign row_len_ext  = {1'b0, data_len} + (RB_W + 1)'(3);
    assign row_len      = {row_len_ext[RB_W-1:2], 2'b00};
    assign row_byte_inc = row_byte_reg + 1'b1;
    assign row_end      = (row_byte_inc == row_len);
    assign in_data      = (row_byte_reg < data_len);
    assign pix_done     = in_data && (({1'b0, bip_reg} + 3'd1) == bpp);

    assign full   = q_full || restart;
    assign accept = push && !full;
    assign q_push = accept && pix_done;

    assign job.part0      = part_reg[0];
    assign job.part1      = part_reg[1];
    assign job.part2      = part_reg[2];
    assign job.final_byte = item.data_byte;
    assign job.background = item.background_color;
    assign job.x          = cfg.origin_x + 16'(col_reg);
    assign job.y          = cfg.origin_y + 16'(row_reg);
    assign job.last       = (row_reg == '0) && ((col_reg + 1'b1) == w_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bip_reg      <= '0;
            row_byte_reg <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
        end
        else if (restart)
        begin
            bip_reg      <= '0;
            row_byte_reg <= '0;
            col_reg      <= '0;
            row_reg      <= h_eff - 1'b1;
        end
        else if (accept)
        begin
            if (row_end)
            begin
                // Rows arrive bottom-up; wrap to the bottom row after the top one.
                row_byte_reg <= '0;
                col_reg      <= '0;
                bip_reg      <= '0;
                if (row_reg == '0)
                    row_reg <= h_eff - 1'b1;
                else
                    row_reg <= row_reg - 1'b1;
            end
            else
            begin
                row_byte_reg <= row_byte_inc;
                if (in_data)
                begin
                    if (pix_done)
                    begin
                        bip_reg <= '0;
                        col_reg <= col_reg + 1'b1;
                    end
                    else
                    begin
                        bip_reg <= bip_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_data && !pix_done)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (bip_reg == 2'(i))
                    part_reg[i] <= item.data_byte;
            end
        end
    end

endmodule

// ===== design/bmp565_queue.sv =====
// Short pixel queue that decouples the front end from the color back end.
`timescale 1ns / 1ps

module bmp565_queue #(
    parameter int DEPTH = bmp565_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  bmp565_pkg::job_t din,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output bmp565_pkg::job_t dout
);
    import bmp565_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == (PTR_W + 1)'(DEPTH));
    assign valid   = (count_reg != '0);
    assign do_push = push && !full;
    assign do_pop  = pop && valid;
    assign dout    = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= din;
    end

endmodule

// ===== design/bmp565_back.sv =====
// Back end: decodes the pixel format, blends 32-bit pixels, holds the result word.
`timescale 1ns / 1ps

module bmp565_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bmp565_pkg::cfg_t      cfg,
    input  logic                  job_valid,
    input  bmp565_pkg::job_t      job,
    output logic                  job_pop,
    output bmp565_pkg::out_item_t result,
    output logic                  empty,
    input  logic                  pop
);
    import bmp565_pkg::*;

    logic [2:0]  bpp;
    logic [1:0]  mode;
    logic [15:0] color;
    logic [15:0] source;

    logic        a_valid_reg;
    logic [15:0] a_color_reg;
    logic [15:0] a_source_reg;
    logic [4:0]  a_alpha_reg;
    logic        a_blend_reg;
    logic [15:0] a_x_reg;
    logic [15:0] a_y_reg;
    logic        a_last_reg;

    logic        out_valid_reg;
    out_item_t   out_reg;

    logic        out_ready;
    logic        a_ready;

    assign bpp  = eff_bpp(cfg.bytes_per_pixel);
    assign mode = cfg.blend_mode[7:6];

    // Stage A: format decode and blend source selection.
    always_comb
    begin
        if (bpp == BPP_16)
        begin
            if (cfg.bitfields_format)
                color = {job.final_byte, job.part0};
            else
                color = {job.final_byte[6:0], job.part0[7:5], 1'b0, job.part0[4:0]};
        end
        else if (bpp == BPP_24)
        begin
            color = {job.final_byte[7:3], job.part1[7:2], job.part0[7:3]};
        end
        else
        begin
            color = {job.part2[7:3], job.part1[7:2], job.part0[7:3]};
        end
    end

    always_comb
    begin
        unique case (mode)
            MODE_COLOR:  source = cfg.blend_color;
            MODE_TINTED: source = blend565(job.background, cfg.blend_color,
                                           cfg.blend_mode[4:0]);
            MODE_BACKGROUND, MODE_BACKGROUND_ALT: source = job.background;
        endcase
    end

    assign out_ready = !out_valid_reg || pop;
    assign a_ready   = !a_valid_reg || out_ready;
    assign job_pop   = job_valid && a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= job_valid;
            if (out_ready)
                out_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            a_color_reg  <= color;
            a_source_reg <= source;
            a_alpha_reg  <= job.final_byte[7:3];
            a_blend_reg  <= (bpp == BPP_32);
            a_x_reg      <= job.x;
            a_y_reg      <= job.y;
            a_last_reg   <= job.last;
        end
        // Stage B: final alpha blend into the result word.
        if (a_valid_reg && out_ready)
        begin
            out_reg <= '{
                pixel_x:     a_x_reg,
                pixel_y:     a_y_reg,
                pixel_color: a_blend_reg ?
                             blend565(a_source_reg, a_color_reg, a_alpha_reg) :
                             a_color_reg,
                last_pixel:  a_last_reg
            };
        end
    end

    assign result = out_reg;
    assign empty  = !out_valid_reg;

endmodule

// ===== design/bmp_pixel_stream_to_rgb565_blend_unit.sv =====
// Top level of the BMP pixel-array to RGB565 streamer with alpha blending.
`timescale 1ns / 1ps

// Push one byte of the BMP pixel array per cycle, row padding included; the
// unit accepts a byte every cycle while its pixel queue has room. Each pixel
// whose last byte arrives gives one RGB565 word with its screen coordinate,
// after it has gone through the pixel queue, the format decode and background
// tint register and the alpha blend into the result register. 32-bit pixels
// are blended with a 5-bit alpha taken from the top bits of the alpha byte.
// Rows are expected bottom-up, and after the padding of the top row the unit
// starts over on the next image. Any configuration write restarts the frame
// and holds full high for one cycle.
module bmp_pixel_stream_to_rgb565_blend_unit #(
    parameter int MAX_WIDTH   = bmp565_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = bmp565_pkg::MAX_HEIGHT_DEF,
    parameter int QUEUE_DEPTH = bmp565_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  bmp565_pkg::in_item_t          item,
    output logic                          full,
    output bmp565_pkg::out_item_t         result,
    output logic                          empty,
    input  logic                          pop,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bmp565_pkg::ADDR_W-1:0] paddr,
    input  logic [bmp565_pkg::DATA_W-1:0] pwdata,
    output logic [bmp565_pkg::DATA_W-1:0] prdata,
    output logic                          pready
);
    import bmp565_pkg::*;

    cfg_t cfg;
    logic restart;
    logic q_full;
    logic q_push;
    logic q_valid;
    logic q_pop;
    job_t job_in;
    job_t job_out;

    bmp565_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .restart (restart)
    );

    bmp565_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .restart (restart),
        .push    (push),
        .item    (item),
        .full    (full),
        .q_full  (q_full),
        .q_push  (q_push),
        .job     (job_in)
    );

    bmp565_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (job_in),
        .full  (q_full),
        .pop   (q_pop),
        .valid (q_valid),
        .dout  (job_out)
    );

    bmp565_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .job_valid (q_valid),
        .job       (job_out),
        .job_pop   (q_pop),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

    // A configuration write must block input for the restart cycle.
    a_restart_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready) |=> full)
        else $error("input not blocked after configuration write");

    // The front end never hands a pixel to a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("pixel pushed into full queue");

    // A queued pixel stays until the back end takes it.
    a_queue_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && !q_pop) |=> q_valid)
        else $error("queued pixel lost");

    // Only an accepted result empties a lone output word with nothing behind it.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result dropped without pop");

endmodule

// ===== verif/bmp_pixel_stream_to_rgb565_blend_unit_tb.sv =====
// Self-checking testbench for the BMP pixel-array to RGB565 blend unit.
`timescale 1ns / 1ps

module bmp_pixel_stream_to_rgb565_blend_unit_tb;
    import bmp565_pkg::*;

    localparam int RANDOM_ITEMS = 480;
    localparam int IDLE_GAP     = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 500000;

    class rgb565_scoreboard;
        cfg_t        regs;
        int unsigned pix_byte;
        int unsigned row_byte;
        int unsigned column;
        int unsigned row;
        logic [23:0] partial;
        out_item_t   expected_pixels[$];
        int          errors;

        function new();
            regs = '0;
            regs.bytes_per_pixel = BPP_16;
            regs.image_width = 11'd1;
            regs.image_height = 11'd1;
            errors = 0;
            restart_frame();
        endfunction

        function int unsigned clamp_dim(input logic [10:0] v, input int unsigned limit);
            if (v == 11'd0)
                return 1;
            if (v > limit)
                return limit;
            return v;
        endfunction

        function int unsigned pixel_bytes();
            if (regs.bytes_per_pixel == BPP_24 || regs.bytes_per_pixel == BPP_32)
                return regs.bytes_per_pixel;
            return 2;
        endfunction

        function int unsigned row_bytes();
            return (clamp_dim(regs.image_width, MAX_WIDTH_DEF) * pixel_bytes() + 3) & ~32'd3;
        endfunction

        function int unsigned frame_bytes();
            return row_bytes() * clamp_dim(regs.image_height, MAX_HEIGHT_DEF);
        endfunction

        function void restart_frame();
            pix_byte = 0;
            row_byte = 0;
            column = 0;
            partial = '0;
            row = clamp_dim(regs.image_height, MAX_HEIGHT_DEF) - 1;
        endfunction

        function void set_reg(input logic [2:0] idx, input logic [31:0] value);
            case (idx)
                REG_BYTES_PER_PIXEL:  regs.bytes_per_pixel = value[2:0];
                REG_BITFIELDS_FORMAT: regs.bitfields_format = value[0];
                REG_IMAGE_WIDTH:      regs.image_width = value[10:0];
                REG_IMAGE_HEIGHT:     regs.image_height = value[10:0];
                REG_ORIGIN_X:         regs.origin_x = value[15:0];
                REG_ORIGIN_Y:         regs.origin_y = value[15:0];
                REG_BLEND_COLOR:      regs.blend_color = value[15:0];
                REG_BLEND_MODE:       regs.blend_mode = value[7:0];
            endcase
            restart_frame();
        endfunction

        // Spread G:R:B so each channel keeps headroom for the product.
        function logic [15:0] mix565(input logic [15:0] s, input logic [15:0] d,
                                     input logic [4:0] a);
            logic [31:0] s2;
            logic [31:0] d2;
            logic [31:0] r;
            s2 = {s, s} & GRB_MASK;
            d2 = {d, d} & GRB_MASK;
            r = (((d2 - s2) * {27'd0, a}) >> 5) + s2;
            r = r & GRB_MASK;
            return r[31:16] | r[15:0];
        endfunction

        function void take_byte(input in_item_t word);
            int unsigned bpp;
            int unsigned w;
            logic [7:0]  b;
            logic [7:0]  b0;
            logic [7:0]  b1;
            logic [7:0]  b2;
            logic [15:0] c;
            logic [15:0] tint;
            out_item_t   px;
            b = word.data_byte;
            bpp = pixel_bytes();
            w = clamp_dim(regs.image_width, MAX_WIDTH_DEF);
            if (row_byte < w * bpp)
            begin
                if (pix_byte + 1 < bpp)
                begin
                    partial = partial | (24'(b) << (8 * pix_byte));
                    pix_byte++;
                end
                else
                begin
                    b0 = partial[7:0];
                    b1 = partial[15:8];
                    b2 = partial[23:16];
                    if (bpp == 2)
                    begin
                        if (regs.bitfields_format)
                            c = {b, b0};
                        else
                            c = {b[6:0], b0[7:5], 1'b0, b0[4:0]};
                    end
                    else
                    begin
                        if (bpp == 3)
                            b2 = b;
                        c = {b2[7:3], b1[7:2], b0[7:3]};
                        if (bpp == 4)
                        begin
                            case (regs.blend_mode[7:6])
                                MODE_COLOR:
                                    c = mix565(regs.blend_color, c, b[7:3]);
                                MODE_TINTED:
                                begin
                                    tint = mix565(word.background_color, regs.blend_color,
                                                  regs.blend_mode[4:0]);
                                    c = mix565(tint, c, b[7:3]);
                                end
                                default:
                                    c = mix565(word.background_color, c, b[7:3]);
                            endcase
                        end
                    end
                    px.pixel_x = 16'(regs.origin_x + column);
                    px.pixel_y = 16'(regs.origin_y + row);
                    px.pixel_color = c;
                    px.last_pixel = (row == 0 && column + 1 == w);
                    expected_pixels.push_back(px);
                    column++;
                    pix_byte = 0;
                    partial = '0;
                end
            end
            row_byte++;
            if (row_byte >= row_bytes())
            begin
                row_byte = 0;
                column = 0;
                pix_byte = 0;
                partial = '0;
                if (row == 0)
                    restart_frame();
                else
                    row--;
            end
        endfunction

        function void note_error(input string msg);
            errors++;
            if (errors <= 10)
                $display("%s", msg);
        endfunction

        function void compare_pixel(input out_item_t got);
            out_item_t want;
            if (expected_pixels.size() == 0)
            begin
                note_error($sformatf("unexpected pixel x=%0d y=%0d color=%h last=%b",
                                     got.pixel_x, got.pixel_y, got.pixel_color,
                                     got.last_pixel));
                return;
            end
            want = expected_pixels.pop_front();
            if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
                got.pixel_color !== want.pixel_color || got.last_pixel !== want.last_pixel)
                note_error($sformatf({"pixel mismatch: expected x=%0d y=%0d color=%h last=%b,",
                                      " got x=%0d y=%0d color=%h last=%b"},
                                     want.pixel_x, want.pixel_y, want.pixel_color,
                                     want.last_pixel, got.pixel_x, got.pixel_y,
                                     got.pixel_color, got.last_pixel));
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    in_item_t    item = '0;
    logic        full;
    out_item_t   result;
    logic        empty;
    logic        pop = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic        pready;

    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;
    int unsigned cycle_count = 0;

    rgb565_scoreboard pixel_board = new();

    bmp_pixel_stream_to_rgb565_blend_unit DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .item    (item),
        .full    (full),
        .result  (result),
        .empty   (empty),
        .pop     (pop),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    initial
    begin
        int stall;
        int g;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
                pixel_board.compare_pixel(result);
            if (hold_req)
            begin
                stall = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (stall > 0)
            begin
                pop <= 1'b0;
                stall--;
            end
            else if (quiet)
                pop <= 1'b1;
            else
            begin
                g = pick_gap();
                pop <= (g == 0);
                if (g > 0)
                    stall = g - 1;
            end
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic [15:0] bg);
        int g;
        in_item_t word;
        word.data_byte = b;
        word.background_color = bg;
        g = quiet ? 0 : pick_gap();
        if (g > 0)
        begin
            push <= 1'b0;
            repeat (g) @(posedge clk);
        end
        push <= 1'b1;
        item <= word;
        do @(posedge clk); while (full);
        pixel_board.take_byte(word);
    endtask

    task automatic push_random(input int n);
        for (int k = 0; k < n; k++)
            push_byte(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
    endtask

    // Stop offering words and wait until every expected pixel is out.
    task automatic drain(input int extra);
        push <= 1'b0;
        do @(posedge clk); while (pixel_board.pending() != 0);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        pixel_board.set_reg(idx, value);
        @(posedge clk);
    endtask

    task automatic blend_pixel(input logic [1:0] mode, input logic [4:0] strength,
                               input logic [7:0] alpha);
        drain(IDLE_GAP);
        write_reg(REG_BLEND_MODE, {24'd0, mode, 1'b0, strength});
        push_random(3);
        push_byte(alpha, 16'($urandom_range(0, 65535)));
    endtask

    task automatic random_setup(input bit all);
        logic [2:0]  idx;
        logic [31:0] value;
        int          pick;
        for (int i = 0; i < 8; i++)
        begin
            idx = 3'(i);
            pick = $urandom_range(0, 19);
            case (idx)
                REG_BYTES_PER_PIXEL:
                    value = (pick < 5) ? $urandom_range(0, 7) : $urandom_range(2, 4);
                REG_BITFIELDS_FORMAT:
                    value = $urandom_range(0, 1);
                REG_IMAGE_WIDTH:
                    value = (pick == 0) ? 0 :
                            (pick == 1) ? $urandom_range(1000, 2047) : $urandom_range(1, 5);
                REG_IMAGE_HEIGHT:
                    value = (pick == 0) ? 0 :
                            (pick == 1) ? $urandom_range(1000, 2047) : $urandom_range(1, 4);
                REG_ORIGIN_X, REG_ORIGIN_Y:
                    value = (pick < 3) ? $urandom_range(65500, 65535) :
                                         $urandom_range(0, 65535);
                REG_BLEND_COLOR:
                    value = $urandom_range(0, 65535);
                REG_BLEND_MODE:
                    value = $urandom_range(0, 255);
            endcase
            if (all || $urandom_range(0, 1))
                write_reg(idx, value);
        end
    endtask

    initial
    begin
        int n;
        int sent;
        bit first;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: one RGB555 pixel per image, then two pad bytes.
        push_byte(8'hFF, 16'hFFFF);
        push_byte(8'hFF, 16'h0000);
        push_byte(8'h00, 16'h0000);
        push_byte(8'h00, 16'hFFFF);

        // 24-bit pixel with both origins at the top of the coordinate range.
        drain(IDLE_GAP);
        write_reg(REG_BYTES_PER_PIXEL, BPP_24);
        write_reg(REG_BITFIELDS_FORMAT, 32'd1);
        write_reg(REG_ORIGIN_X, 32'hFFFF);
        write_reg(REG_ORIGIN_Y, 32'hFFFF);
        push_byte(8'h00, 16'h0000);
        push_byte(8'hFF, 16'hFFFF);
        push_byte(8'h5A, 16'h0000);
        push_random(1);

        // Every blend mode once, alpha at its extremes, strength at both ends and mid-scale.
        drain(IDLE_GAP);
        write_reg(REG_BYTES_PER_PIXEL, BPP_32);
        write_reg(REG_ORIGIN_X, 32'd0);
        write_reg(REG_ORIGIN_Y, 32'd0);
        write_reg(REG_BLEND_COLOR, 32'($urandom_range(0, 65535)));
        blend_pixel(MODE_BACKGROUND, 5'd0, 8'hFF);
        blend_pixel(MODE_COLOR, 5'd31, 8'h00);
        blend_pixel(MODE_TINTED, 5'd31, 8'hF8);
        blend_pixel(MODE_BACKGROUND_ALT, 5'd16, 8'h07);

        // Odd pixel size acts as 16-bit; oversized dimensions saturate.
        drain(IDLE_GAP);
        write_reg(REG_BYTES_PER_PIXEL, 32'd7);
        write_reg(REG_BITFIELDS_FORMAT, 32'd0);
        write_reg(REG_IMAGE_WIDTH, 32'd2047);
        write_reg(REG_IMAGE_HEIGHT, 32'd2047);
        write_reg(REG_ORIGIN_X, 32'hFFFF);
        write_reg(REG_ORIGIN_Y, 32'hFFFF);
        push_random(2);

        // Hold the result side off while words keep coming, so input backs up.
        drain(IDLE_GAP);
        write_reg(REG_BYTES_PER_PIXEL, BPP_16);
        write_reg(REG_BITFIELDS_FORMAT, 32'd1);
        write_reg(REG_IMAGE_WIDTH, 32'd2);
        write_reg(REG_IMAGE_HEIGHT, 32'd3);
        quiet = 1'b1;
        hold_req = 1'b1;
        push_random(24);
        drain(0);
        push_random(12);

        sent = 0;
        first = 1'b1;
        while (sent < RANDOM_ITEMS)
        begin
            drain(IDLE_GAP);
            quiet = ($urandom_range(0, 3) == 0);
            random_setup(first);
            first = 1'b0;
            n = pixel_board.frame_bytes();
            if (n > 200)
                n = $urandom_range(4, 48);
            else
                n = n * $urandom_range(1, 2);
            // Cut some frames short.
            if ($urandom_range(0, 4) == 0)
                n = $urandom_range(1, n);
            for (int k = 0; k < n; k++)
            begin
                if ($urandom_range(0, 49) == 0)
                    drain(0);
                push_random(1);
            end
            sent += n;
        end

        drain(IDLE_GAP);
        if (pixel_board.errors == 0 && pixel_board.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
